/* hw/rtl/sbtc_pkg.sv */
package sbtc_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 256;
  localparam int DEFAULT_MAX_HEIGHT = 256;

  // A texel is a hull candidate when a frame's neighbor count is below this.
  localparam int NEIGHBOR_LIMIT = 5;

  localparam logic [8:0] RESET_SUB_WIDTH  = 9'd64;
  localparam logic [8:0] RESET_SUB_HEIGHT = 9'd64;

  // Number of result lanes: one for each position an item can decide.
  localparam int LANES = 4;

  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_OPACITY_MODE = 2'd1,
    REG_SUB_WIDTH    = 2'd2,
    REG_SUB_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OPQ_BYTE3 = 3'd0,
    OPQ_BYTE0 = 3'd1,
    OPQ_BYTE1 = 3'd2,
    OPQ_BYTE2 = 3'd3,
    OPQ_MEAN  = 3'd4
  } opacity_mode_t;

  typedef struct packed {
    logic [31:0] texel_now;
    logic [31:0] texel_next;
  } texel_item_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       is_candidate;
    logic       run_last;
    logic       image_done;
  } result_item_t;

  // One lane's finding, handed to the result buffer.
  typedef struct packed {
    logic         en;
    result_item_t item;
  } lane_result_t;

  // 3x3 neighborhood of two-bit opacity codes (bit 0 now, bit 1 next).
  typedef logic [2:0][2:0][1:0] window_t;

  // Opacity byte of a texel. The mean of three bytes uses a reciprocal
  // multiply: floor(s * 683 / 2048) equals floor(s / 3) for s up to 765.
  function automatic logic [7:0] opacity_of(logic [31:0] texel, logic [2:0] mode);
    logic [9:0]  sum;
    logic [19:0] scaled;
    logic [7:0]  value;
    sum    = 10'(texel[7:0]) + 10'(texel[15:8]) + 10'(texel[23:16]);
    scaled = 20'(sum) * 20'd683;
    case (mode)
      OPQ_BYTE3: value = texel[31:24];
      OPQ_BYTE0: value = texel[7:0];
      OPQ_BYTE1: value = texel[15:8];
      OPQ_BYTE2: value = texel[23:16];
      default:   value = scaled[18:11];
    endcase
    return value;
  endfunction

endpackage

/* hw/rtl/sbtc_ram.sv */
module sbtc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/sbtc_lane.sv */
module sbtc_lane (
  input  sbtc_pkg::window_t win,
  output logic              cand
);

  logic [3:0] cnt_now;
  logic [3:0] cnt_next;
  logic [1:0] centre;

  always_comb begin
    cnt_now  = '0;
    cnt_next = '0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        if (!(dy == 1 && dx == 1)) begin
          cnt_now  = cnt_now + 4'(win[dy][dx][0]);
          cnt_next = cnt_next + 4'(win[dy][dx][1]);
        end
      end
    end
  end

  // A transparent frame counts as fully surrounded, so only an opaque frame
  // with a sparse neighborhood makes the texel a candidate.
  assign centre = win[1][1];
  assign cand = (centre[0] && (cnt_now < 4'(sbtc_pkg::NEIGHBOR_LIMIT))) ||
                (centre[1] && (cnt_next < 4'(sbtc_pkg::NEIGHBOR_LIMIT)));

endmodule

/* hw/rtl/sbtc_result_buf.sv */
module sbtc_result_buf (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       load,
  input  sbtc_pkg::lane_result_t [sbtc_pkg::LANES-1:0] lanes,
  output logic                                       can_load,
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output sbtc_pkg::result_item_t                     result
);

  logic [sbtc_pkg::LANES-1:0]      mask;
  logic [sbtc_pkg::LANES-1:0]      mask_next;
  logic [sbtc_pkg::LANES-1:0]      head;
  sbtc_pkg::result_item_t          items [sbtc_pkg::LANES];
  logic [$clog2(sbtc_pkg::LANES)-1:0] head_idx;

  // The lowest pending lane goes out first, which keeps raster order.
  assign head = mask & (~mask + 1'b1);

  always_comb begin
    head_idx = '0;
    for (int i = sbtc_pkg::LANES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        head_idx = ($clog2(sbtc_pkg::LANES))'(i);
      end
    end
  end

  assign result_valid = |mask;
  assign result       = items[head_idx];

  always_comb begin
    mask_next = mask;
    if (result_valid && !result_stall) begin
      mask_next = mask & ~head;
    end
  end

  assign can_load = (mask_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      for (int i = 0; i < sbtc_pkg::LANES; i++) begin
        mask[i] <= lanes[i].en;
      end
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < sbtc_pkg::LANES; i++) begin
        items[i] <= lanes[i].item;
      end
    end
  end

endmodule

/* hw/rtl/sprite_boundary_texel_classifier.sv */
// Sprite boundary texel classifier.
// Texel items arrive in raster order on the texel channel (texel_valid,
// texel_stall, texel); each carries the current-frame and next-frame texel
// of one position of a sub_width x sub_height sub-image. Decisions leave on
// the result channel (result_valid, result_stall, result) in raster order,
// one per handshake, each texel decided exactly once. An item yields zero to
// four results; run_last marks the last one it caused. The user must write
// configuration over the APB port while no item is in flight; the block does
// not enforce it. Writing sub_width or sub_height restarts the sub-image.
// Each item passes the classify stage register into the result buffer.
// Throughput: one item per cycle as long as each item yields at most one
// result; the single result port sets the limit, so an item with several
// results holds the input while they drain. The classify stage waits for
// the four-entry result buffer, which drains one entry a cycle. When the
// receiver stalls, the result buffer holds its item and the input stalls
// once the classify stage is full; nothing is lost or repeated.
// Reset clears the registers to their reset values, empties the pipeline
// and restarts at row 0, column 0. The two row stores are not cleared: an
// entry is read only after the same sub-image has written it.
module sprite_boundary_texel_classifier #(
  parameter int MAX_WIDTH  = sbtc_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbtc_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   texel_valid,
  output logic                   texel_stall,
  input  sbtc_pkg::texel_item_t  texel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output sbtc_pkg::result_item_t result
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [7:0] threshold;
  logic [2:0] opacity_mode;
  logic [8:0] sub_width;
  logic [8:0] sub_height;
  logic       cfg_write;
  logic       restart;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (sbtc_pkg::cfg_reg_t'(paddr[3:2]))
      sbtc_pkg::REG_THRESHOLD:    prdata = 32'(threshold);
      sbtc_pkg::REG_OPACITY_MODE: prdata = 32'(opacity_mode);
      sbtc_pkg::REG_SUB_WIDTH:    prdata = 32'(sub_width);
      sbtc_pkg::REG_SUB_HEIGHT:   prdata = 32'(sub_height);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      opacity_mode <= sbtc_pkg::OPQ_BYTE3;
      sub_width    <= sbtc_pkg::RESET_SUB_WIDTH;
      sub_height   <= sbtc_pkg::RESET_SUB_HEIGHT;
    end else if (cfg_write) begin
      case (sbtc_pkg::cfg_reg_t'(paddr[3:2]))
        sbtc_pkg::REG_THRESHOLD:    threshold    <= pwdata[7:0];
        sbtc_pkg::REG_OPACITY_MODE: opacity_mode <= pwdata[2:0];
        sbtc_pkg::REG_SUB_WIDTH:    sub_width    <= pwdata[8:0];
        sbtc_pkg::REG_SUB_HEIGHT:   sub_height   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write &&
                   ((sbtc_pkg::cfg_reg_t'(paddr[3:2]) == sbtc_pkg::REG_SUB_WIDTH) ||
                    (sbtc_pkg::cfg_reg_t'(paddr[3:2]) == sbtc_pkg::REG_SUB_HEIGHT));

  // Last column and last row, with a zero size taken as one and an oversized
  // one taken as the maximum.
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;

  always_comb begin
    if (sub_width == '0) begin
      wlast = '0;
    end else if (32'(sub_width) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(sub_width - 9'd1);
    end
    if (sub_height == '0) begin
      hlast = '0;
    end else if (32'(sub_height) > MAX_HEIGHT) begin
      hlast = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast = RW'(sub_height - 9'd1);
    end
  end

  // Input stage: position counters, opacity bits and the row store read.
  logic          texel_accept;
  logic [CW-1:0] col_counter;
  logic [RW-1:0] row_counter;
  logic          at_last_col;
  logic          at_last_row;
  logic [1:0]    cur_bits;

  assign at_last_col = (col_counter == wlast);
  assign at_last_row = (row_counter == hlast);

  assign cur_bits = {
    sbtc_pkg::opacity_of(texel.texel_next, opacity_mode) > threshold,
    sbtc_pkg::opacity_of(texel.texel_now, opacity_mode) > threshold
  };

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (texel_accept) begin
      if (at_last_col) begin
        col_counter <= '0;
        row_counter <= at_last_row ? '0 : row_counter + 1'b1;
      end else begin
        col_counter <= col_counter + 1'b1;
      end
    end
  end

  // Classify stage. Its row store read data arrives from the RAM; when the
  // previous item wrote the same column in the cycle of the read, that
  // write is forwarded instead.
  logic          s1_valid;
  logic          s1_adv;
  logic [CW-1:0] s1_c;
  logic [RW-1:0] s1_r;
  logic [1:0]    s1_cur;
  logic          s1_r_ge1;
  logic          s1_r_ge2;
  logic          s1_c_ge1;
  logic          s1_c_ge2;
  logic          s1_last_col;
  logic          s1_last_row;
  logic          s1_byp;
  logic [3:0]    s1_byp_data;
  logic          can_load;
  logic [3:0]    ram_rdata;
  logic [3:0]    store_rd;
  logic [3:0]    store_wr;
  logic [1:0]    top_bits;
  logic [1:0]    mid_bits;
  logic [5:0]    newcol;
  logic [5:0]    wc0;
  logic [5:0]    wc1;

  assign s1_adv       = s1_valid && can_load;
  assign texel_stall  = s1_valid && !s1_adv;
  assign texel_accept = texel_valid && !texel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (texel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (texel_accept) begin
      s1_c        <= col_counter;
      s1_r        <= row_counter;
      s1_cur      <= cur_bits;
      s1_r_ge1    <= (row_counter != '0);
      s1_r_ge2    <= (row_counter > RW'(1));
      s1_c_ge1    <= (col_counter != '0);
      s1_c_ge2    <= (col_counter > CW'(1));
      s1_last_col <= at_last_col;
      s1_last_row <= at_last_row;
      s1_byp      <= s1_adv && (s1_c == col_counter);
      s1_byp_data <= store_wr;
    end
  end

  // Each entry holds {row r-2, row r-1} for its column.
  sbtc_ram #(
    .WIDTH(4),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_c),
    .wdata(store_wr),
    .re   (texel_accept),
    .raddr(col_counter),
    .rdata(ram_rdata)
  );

  assign store_rd = s1_byp ? s1_byp_data : ram_rdata;
  assign store_wr = {store_rd[1:0], s1_cur};
  assign top_bits = s1_r_ge2 ? store_rd[3:2] : 2'b00;
  assign mid_bits = s1_r_ge1 ? store_rd[1:0] : 2'b00;
  assign newcol   = {s1_cur, mid_bits, top_bits};

  // Two-column window; it empties at the end of each row.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wc0 <= '0;
      wc1 <= '0;
    end else if (s1_adv) begin
      if (s1_last_col) begin
        wc0 <= '0;
        wc1 <= '0;
      end else begin
        wc1 <= wc0;
        wc0 <= newcol;
      end
    end
  end

  // 4x4 grid: rows r-2..r+1, columns c-2..c+1. Row r+1 and column c+1 lie
  // outside the sub-image whenever a lane uses them, so they hold zero.
  logic [3:0][5:0]       cols;
  logic [3:0][3:0][1:0]  grid;

  always_comb begin
    cols[0] = s1_c_ge2 ? wc1 : 6'd0;
    cols[1] = s1_c_ge1 ? wc0 : 6'd0;
    cols[2] = newcol;
    cols[3] = 6'd0;
    for (int gx = 0; gx < 4; gx++) begin
      for (int gy = 0; gy < 3; gy++) begin
        grid[gy][gx] = cols[gx][2*gy +: 2];
      end
      grid[3][gx] = 2'b00;
    end
  end

  // Lane i decides the texel at row offset i/2 and column offset i%2 from
  // (r-1, c-1): the upper-left neighbor, the upper neighbor at a row end,
  // the left neighbor on the last row, and the final texel itself.
  logic [sbtc_pkg::LANES-1:0]                  lane_en;
  logic [sbtc_pkg::LANES-1:0]                  lane_cand;
  sbtc_pkg::lane_result_t [sbtc_pkg::LANES-1:0] lanes;
  logic [7:0]                                  row_prev;
  logic [7:0]                                  row_here;
  logic [7:0]                                  col_prev;
  logic [7:0]                                  col_here;

  assign lane_en[0] = s1_r_ge1 && s1_c_ge1;
  assign lane_en[1] = s1_r_ge1 && s1_last_col;
  assign lane_en[2] = s1_last_row && s1_c_ge1;
  assign lane_en[3] = s1_last_row && s1_last_col;

  assign row_here = 8'(s1_r);
  assign row_prev = 8'(s1_r - 1'b1);
  assign col_here = 8'(s1_c);
  assign col_prev = 8'(s1_c - 1'b1);

  for (genvar i = 0; i < sbtc_pkg::LANES; i++) begin : g_lane
    sbtc_pkg::window_t win;

    always_comb begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          win[dy][dx] = grid[dy + i / 2][dx + i % 2];
        end
      end
    end

    sbtc_lane u_lane (
      .win (win),
      .cand(lane_cand[i])
    );

    always_comb begin
      lanes[i].en                = lane_en[i];
      lanes[i].item.col          = (i % 2 == 1) ? col_here : col_prev;
      lanes[i].item.row          = (i / 2 == 1) ? row_here : row_prev;
      lanes[i].item.is_candidate = lane_cand[i];
      lanes[i].item.run_last     = lane_en[i] && ((lane_en >> (i + 1)) == '0);
      lanes[i].item.image_done   = (i == sbtc_pkg::LANES - 1);
    end
  end

  sbtc_result_buf u_result_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_adv),
    .lanes       (lanes),
    .can_load    (can_load),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // The final texel's decision is always the last one its item causes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.image_done |-> result.run_last)
    else $error("image_done result is not the last of its item");

  // A classify stage that cannot move on keeps its item.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv && !restart |=> s1_valid && $stable(s1_c) && $stable(s1_r))
    else $error("classify stage lost or changed a held item");

  // The position counters never leave the sub-image.
  assert property (@(posedge clk) disable iff (rst)
    col_counter <= wlast && row_counter <= hlast)
    else $error("position counter outside the sub-image");

endmodule

/* dv/sprite_boundary_texel_classifier_test.sv */
`timescale 1ns / 1ps

module sprite_boundary_texel_classifier_test;

  // Unused opacity modes; the block treats them as the three-byte mean.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // A texel that is transparent in a frame gets this neighbor count.
  localparam int TRANSPARENT_COUNT = 8;

  localparam int RANDOM_ITEMS  = 245;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int REPORT_LIMIT  = 30;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  // One row of the directed table. Rows marked pinned carry the decision
  // typed in by hand; the rest are checked against the predictor.
  typedef struct {
    row_kind_t              kind;
    sbtc_pkg::cfg_reg_t     addr;
    logic [31:0]            value;
    sbtc_pkg::texel_item_t  item;
    logic                   pinned;
    sbtc_pkg::result_item_t want;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   texel_valid = 1'b0;
  logic                   texel_stall;
  sbtc_pkg::texel_item_t  texel = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  sbtc_pkg::result_item_t result;

  sprite_boundary_texel_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .texel_valid  (texel_valid),
    .texel_stall  (texel_stall),
    .texel        (texel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: its registers, the two row stores, the
  // two-column window and the raster position of the next texel.
  logic [7:0] thr_q = 8'd0;
  logic [2:0] mode_q = sbtc_pkg::OPQ_BYTE3;
  logic [8:0] width_q = sbtc_pkg::RESET_SUB_WIDTH;
  logic [8:0] height_q = sbtc_pkg::RESET_SUB_HEIGHT;
  logic [1:0] upper_q [sbtc_pkg::DEFAULT_MAX_WIDTH];
  logic [1:0] middle_q [sbtc_pkg::DEFAULT_MAX_WIDTH];
  logic [5:0] win_q [2] = '{6'd0, 6'd0};
  int         col_q = 0;
  int         row_q = 0;

  // 4x4 neighborhood: rows r-2..r+1 by columns c-2..c+1 of the current texel.
  logic [1:0] grid [4][4];

  // Decisions that the latest accepted item causes, in output order.
  sbtc_pkg::result_item_t fresh [sbtc_pkg::LANES];
  int                     fresh_count;

  sbtc_pkg::result_item_t expected_decisions [$];
  step_t                  directed_steps [$];
  int                     fail_count = 0;
  int                     burst_left = 0;

  // Receiver stall pattern.
  int   stall_left = 0;
  int   stall_pct = 30;
  int   pattern_age = 0;
  logic stall_now = 1'b0;

  function automatic int side_of(logic [8:0] raw, int limit);
    if (raw == 9'd0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic logic [7:0] pick_opacity(logic [31:0] t);
    int sum;
    sum = int'(t[7:0]) + int'(t[15:8]) + int'(t[23:16]);
    case (mode_q)
      sbtc_pkg::OPQ_BYTE3: return t[31:24];
      sbtc_pkg::OPQ_BYTE0: return t[7:0];
      sbtc_pkg::OPQ_BYTE1: return t[15:8];
      sbtc_pkg::OPQ_BYTE2: return t[23:16];
      default:             return 8'(sum / 3);
    endcase
  endfunction

  // Candidate vote for the texel at grid[gy][gx].
  function automatic logic hull_vote(int gy, int gx);
    logic [1:0] centre;
    logic [1:0] v;
    int         now_n;
    int         next_n;
    centre = grid[gy][gx];
    now_n = 0;
    next_n = 0;
    if (centre == 2'b00) return 1'b0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        if (dy == 1 && dx == 1) continue;
        v = grid[(gy + dy - 1) & 3][(gx + dx - 1) & 3];
        now_n += v[0];
        next_n += v[1];
      end
    end
    if (!centre[0]) now_n = TRANSPARENT_COUNT;
    if (!centre[1]) next_n = TRANSPARENT_COUNT;
    return (now_n < sbtc_pkg::NEIGHBOR_LIMIT) || (next_n < sbtc_pkg::NEIGHBOR_LIMIT);
  endfunction

  function automatic void add_decision(logic cand, int r, int c, logic done);
    fresh[fresh_count] = '{col: 8'(c), row: 8'(r), is_candidate: cand,
                           run_last: 1'b0, image_done: done};
    fresh_count++;
  endfunction

  function automatic void restart_image();
    win_q[0] = '0;
    win_q[1] = '0;
    col_q = 0;
    row_q = 0;
  endfunction

  function automatic void apply_setting(sbtc_pkg::cfg_reg_t addr, logic [31:0] value);
    case (addr)
      sbtc_pkg::REG_THRESHOLD:    thr_q = value[7:0];
      sbtc_pkg::REG_OPACITY_MODE: mode_q = value[2:0];
      sbtc_pkg::REG_SUB_WIDTH: begin
        width_q = value[8:0];
        restart_image();
      end
      sbtc_pkg::REG_SUB_HEIGHT: begin
        height_q = value[8:0];
        restart_image();
      end
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one texel item and fills fresh[] with the
  // decisions that item releases.
  function automatic void predict_decisions(sbtc_pkg::texel_item_t it);
    int         w;
    int         h;
    int         r;
    int         c;
    logic [1:0] cur;
    logic [1:0] top;
    logic [1:0] mid;
    logic [5:0] newcol;
    logic [5:0] cols [4];
    w = side_of(width_q, sbtc_pkg::DEFAULT_MAX_WIDTH);
    h = side_of(height_q, sbtc_pkg::DEFAULT_MAX_HEIGHT);
    r = row_q;
    c = col_q;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    cur = {pick_opacity(it.texel_next) > thr_q, pick_opacity(it.texel_now) > thr_q};
    top = (r >= 2) ? upper_q[c] : 2'b00;
    mid = (r >= 1) ? middle_q[c] : 2'b00;
    upper_q[c] = middle_q[c];
    middle_q[c] = cur;
    newcol = {cur, mid, top};
    cols[0] = (c >= 2) ? win_q[1] : 6'd0;
    cols[1] = (c >= 1) ? win_q[0] : 6'd0;
    cols[2] = newcol;
    cols[3] = 6'd0;
    for (int gy = 0; gy < 4; gy++)
      for (int gx = 0; gx < 4; gx++)
        grid[gy][gx] = (gy < 3) ? cols[gx][2 * gy +: 2] : 2'b00;

    fresh_count = 0;
    if (r >= 1) begin
      if (c >= 1) add_decision(hull_vote(1, 1), r - 1, c - 1, 1'b0);
      if (c == w - 1) add_decision(hull_vote(1, 2), r - 1, c, 1'b0);
    end
    if (r == h - 1) begin
      if (c >= 1) add_decision(hull_vote(2, 1), r, c - 1, 1'b0);
      if (c == w - 1) add_decision(hull_vote(2, 2), r, c, 1'b1);
    end
    if (fresh_count > 0) fresh[fresh_count - 1].run_last = 1'b1;

    win_q[1] = win_q[0];
    win_q[0] = newcol;
    if (c == w - 1) begin
      win_q[0] = '0;
      win_q[1] = '0;
      col_q = 0;
      row_q = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
      row_q = r;
    end
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_decision(sbtc_pkg::result_item_t got);
    sbtc_pkg::result_item_t want;
    if (expected_decisions.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d col %0d", got.row, got.col));
      return;
    end
    want = expected_decisions.pop_front();
    if (got.col !== want.col)
      report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
    if (got.row !== want.row)
      report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
    if (got.is_candidate !== want.is_candidate)
      report_mismatch($sformatf("is_candidate %b, expected %b at row %0d col %0d",
                                got.is_candidate, want.is_candidate, want.row, want.col));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %b, expected %b at row %0d col %0d",
                                got.run_last, want.run_last, want.row, want.col));
    if (got.image_done !== want.image_done)
      report_mismatch($sformatf("image_done %b, expected %b at row %0d col %0d",
                                got.image_done, want.image_done, want.row, want.col));
  endtask

  // Result side. Every accepted decision is checked against the oldest one
  // still expected. The stall line follows its own pattern: alternating
  // stall and free stretches, with the stall density redrawn from four levels,
  // one of them zero, so that some stretches never stall at all.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) check_decision(result);
    pattern_age++;
    if (pattern_age >= 150) begin
      pattern_age = 0;
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    if (stall_left == 0) begin
      stall_now = ($urandom_range(99) < stall_pct);
      stall_left = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 20);
    end
    stall_left--;
    result_stall <= stall_now;
  end

  // Offers one item and holds it until the block takes it; the predictor
  // then runs for that item. A pinned row supplies its own expectation.
  task automatic drive_texel(sbtc_pkg::texel_item_t it, logic pinned,
                             sbtc_pkg::result_item_t want);
    texel_valid <= 1'b1;
    texel <= it;
    @(posedge clk);
    while (texel_stall !== 1'b0) @(posedge clk);
    predict_decisions(it);
    if (pinned) expected_decisions.push_back(want);
    else for (int k = 0; k < fresh_count; k++) expected_decisions.push_back(fresh[k]);
  endtask

  // Register write followed by a read-back of the same register. Ends by
  // idling the bus so that back-to-back calls never lower and raise psel in
  // the same time step.
  task automatic write_reg(sbtc_pkg::cfg_reg_t addr, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {addr, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_setting(addr, value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (addr)
      sbtc_pkg::REG_THRESHOLD:    want = 32'(thr_q);
      sbtc_pkg::REG_OPACITY_MODE: want = 32'(mode_q);
      sbtc_pkg::REG_SUB_WIDTH:    want = 32'(width_q);
      default:                    want = 32'(height_q);
    endcase
    if (prdata !== want)
      report_mismatch($sformatf("register %s reads %0h, expected %0h", addr.name(), prdata,
                                want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Lets the block run dry before a register write: every expected decision
  // has to arrive, then a settling wait covers items that release nothing.
  task automatic settle();
    texel_valid <= 1'b0;
    do @(posedge clk); while (expected_decisions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Texel whose bytes all sit on one side of the current threshold, so every
  // opacity mode agrees; now and then a fully random texel instead.
  function automatic logic [31:0] make_texel(logic opaque);
    logic [31:0] t;
    if ($urandom_range(99) < 15) return $urandom();
    for (int k = 0; k < 4; k++) begin
      if (opaque && thr_q != 8'hFF) t[8 * k +: 8] = 8'($urandom_range(255, int'(thr_q) + 1));
      else t[8 * k +: 8] = 8'($urandom_range(int'(thr_q), 0));
    end
    return t;
  endfunction

  // Streams count items in bursts with random gaps. Once in a while the
  // sender holds off until every expected decision has come back.
  task automatic feed(int count, int dens);
    logic                  on_now;
    logic                  on_next;
    sbtc_pkg::texel_item_t it;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(3) != 0) begin
          texel_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end else if ($urandom_range(49) == 0) begin
        texel_valid <= 1'b0;
        do @(posedge clk); while (expected_decisions.size() != 0);
      end
      burst_left--;
      on_now = ($urandom_range(99) < dens);
      on_next = ($urandom_range(99) < 70) ? on_now : !on_now;
      it.texel_now = make_texel(on_now);
      it.texel_next = make_texel(on_next);
      drive_texel(it, 1'b0, '0);
    end
  endtask

  function automatic step_t cfg_row(sbtc_pkg::cfg_reg_t addr, logic [31:0] value);
    step_t s;
    s.kind = ROW_CFG;
    s.addr = addr;
    s.value = value;
    s.item = '0;
    s.pinned = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t texel_row(logic [31:0] now_t, logic [31:0] next_t);
    step_t s;
    s = cfg_row(sbtc_pkg::REG_THRESHOLD, '0);
    s.kind = ROW_ITEM;
    s.item = '{texel_now: now_t, texel_next: next_t};
    return s;
  endfunction

  // A one-texel sub-image: the item decides itself at once, so the expected
  // decision is obvious: opaque in either frame means candidate.
  function automatic step_t solo_row(logic [31:0] now_t, logic [31:0] next_t, logic cand);
    step_t s;
    s = texel_row(now_t, next_t);
    s.pinned = 1'b1;
    s.want = '{col: 8'd0, row: 8'd0, is_candidate: cand, run_last: 1'b1, image_done: 1'b1};
    return s;
  endfunction

  initial begin
    int w;
    int h;
    int span;
    int thr_pick;
    int done_items;

    // Single-texel images: threshold extremes, every opacity mode, two of the
    // unused codes, and a zero size that must read as one.
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_WIDTH, 32'd1));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_HEIGHT, 32'd1));
    directed_steps.push_back(solo_row(32'h0000_0000, 32'h0000_0000, 1'b0));
    directed_steps.push_back(solo_row(32'hFF00_0000, 32'h0000_0000, 1'b1));
    directed_steps.push_back(solo_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    directed_steps.push_back(solo_row(32'h0100_0000, 32'h0100_0000, 1'b1));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_THRESHOLD, 32'd255));
    directed_steps.push_back(solo_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_THRESHOLD, 32'd254));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(sbtc_pkg::OPQ_BYTE0)));
    directed_steps.push_back(solo_row(32'h0000_00FF, 32'h0000_0000, 1'b1));
    directed_steps.push_back(solo_row(32'hFFFF_FF00, 32'hFFFF_FF00, 1'b0));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(sbtc_pkg::OPQ_BYTE1)));
    directed_steps.push_back(solo_row(32'h0000_FF00, 32'h0000_0000, 1'b1));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(sbtc_pkg::OPQ_BYTE2)));
    directed_steps.push_back(solo_row(32'h0000_0000, 32'h00FF_0000, 1'b1));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(sbtc_pkg::OPQ_MEAN)));
    directed_steps.push_back(solo_row(32'h00FF_FFFF, 32'h0000_0000, 1'b1));
    // Mean of 255, 255 and 254 truncates to 254, which is not above 254.
    directed_steps.push_back(solo_row(32'h00FF_FFFE, 32'h0000_0000, 1'b0));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(MODE_SPARE_HI)));
    directed_steps.push_back(solo_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(MODE_SPARE_LO)));
    directed_steps.push_back(solo_row(32'hFF00_0000, 32'h0000_0000, 1'b0));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_WIDTH, 32'd0));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_HEIGHT, 32'd0));
    directed_steps.push_back(solo_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
    // A full 3x3 image mixing interior, edge and corner texels.
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_WIDTH, 32'd3));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_SUB_HEIGHT, 32'd3));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_OPACITY_MODE, 32'(sbtc_pkg::OPQ_BYTE3)));
    directed_steps.push_back(cfg_row(sbtc_pkg::REG_THRESHOLD, 32'd127));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'hFF00_0000));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'h8000_0000));
    directed_steps.push_back(texel_row(32'h0000_0000, 32'hFF00_0000));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'hFF00_0000));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'h7F00_0000));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'hFF00_0000));
    directed_steps.push_back(texel_row(32'h8000_0000, 32'h0000_0000));
    directed_steps.push_back(texel_row(32'hFF00_0000, 32'hFF00_0000));
    directed_steps.push_back(texel_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_steps[i].addr, directed_steps[i].value);
      end else begin
        drive_texel(directed_steps[i].item, directed_steps[i].pinned, directed_steps[i].want);
      end
    end

    // Random phases. Most phases stream whole sub-images of small size; some
    // stop part way, and the next size write restarts the image. Phases that
    // skip the size write change threshold and mode in the middle of an image.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(3) != 0) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        case ($urandom_range(9))
          0: w = 0;
          1: h = 0;
          2: begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 3);
          end
          default: ;
        endcase
        write_reg(sbtc_pkg::REG_SUB_WIDTH, 32'(w));
        write_reg(sbtc_pkg::REG_SUB_HEIGHT, 32'(h));
      end
      case ($urandom_range(9))
        0:       thr_pick = 0;
        1:       thr_pick = 255;
        default: thr_pick = $urandom_range(255);
      endcase
      write_reg(sbtc_pkg::REG_THRESHOLD, 32'(thr_pick));
      write_reg(sbtc_pkg::REG_OPACITY_MODE, 32'($urandom_range(7)));
      w = side_of(width_q, sbtc_pkg::DEFAULT_MAX_WIDTH);
      h = side_of(height_q, sbtc_pkg::DEFAULT_MAX_HEIGHT);
      if ($urandom_range(4) != 0)
        span = w * h - (row_q * w + col_q) + w * h * int'($urandom_range(1));
      else
        span = $urandom_range(1, w * h);
      feed(span, $urandom_range(10, 95));
      done_items += span;
    end

    texel_valid <= 1'b0;
    do @(posedge clk); while (expected_decisions.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Several times the slowest correct run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
